### hdl/keyed_runtime_accumulator_unit_assert.svh
// assertion macros for the keyed runtime accumulator checker
// expects signals named clk and rst_n in the scope of each use
`ifndef KEYED_RUNTIME_ACCUMULATOR_UNIT_ASSERT_SVH
`define KEYED_RUNTIME_ACCUMULATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define KRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define KRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/kra_pkg.sv
// shared types and constants for the keyed runtime accumulator
// no dependencies
`timescale 1ns / 1ps

package kra_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 32;

  // request kinds
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [2:0] {
    STAT_HIT    = 3'd0,
    STAT_NEW    = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_RD_OK  = 3'd3,
    STAT_RD_BAD = 3'd4
  } kra_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ
  } kra_state_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] domain_id;
    logic [31:0] slice_time;
    logic [4:0]  read_index;
  } kra_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  entry_count;
    logic [15:0] out_domain_id;
    logic [63:0] out_runtime;
    logic [63:0] out_total;
  } kra_res_t;

  typedef struct packed {
    logic [15:0] domain;
    logic [63:0] runtime;
  } kra_entry_t;

  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic        emit;
    kra_status_t status;
  } kra_ctl_t;

endpackage

### hdl/keyed_runtime_accumulator_unit.sv
// top level of the keyed runtime accumulator
// depends on kra_pkg, kra_seq and kra_ram
`timescale 1ns / 1ps

// keyed runtime accumulator
//
// input channel: an item is taken at a rising edge with start high and busy
// low. req_type add folds slice_time into the entry of domain_id (appending a
// new entry if the domain is unknown and there is room) and always into the
// grand total; req_type read returns the entry at read_index.
// result channel: one result per item, held on out_result for exactly one
// cycle while out_valid is high. the receiver cannot stall the block.
// table: the entries live in one single-port ram with a registered read. an
// add scans the used entries one per cycle, then writes back the match or a
// new entry, or drops the slice if the table is full; on an empty table the
// first entry is written without a scan. a read fetches the entry at
// read_index, or is answered without a ram read beyond the count.
// the ram read port sets the pace: busy stays high until the result strobe.
// reset: synchronous on rst_n, clears the count, the total and the sequencer.
// table contents are not cleared; only entries below the count are ever read.

module keyed_runtime_accumulator_unit #(
  parameter int unsigned TABLE_ENTRIES = kra_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  kra_pkg::kra_req_t in_req,
  output logic              out_valid,
  output kra_pkg::kra_res_t out_result
);
  import kra_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  kra_ctl_t         ctl;
  logic [IDX_W-1:0] addr;
  logic [CNT_W-1:0] count;
  logic [8:0]       cnt_ext;
  logic             accept;
  logic             hit;

  // request held for the scan
  logic [15:0] dom_r, dom_nxt;
  logic [31:0] slice_r, slice_nxt;
  logic [15:0] cur_dom;
  logic [31:0] cur_slice;

  logic [63:0] total_r, total_nxt;
  logic        out_valid_r;
  kra_res_t    out_res_r, out_res_nxt;

  kra_entry_t  rd_entry;
  kra_entry_t  wr_entry;
  logic [63:0] sum;

  assign accept = start && !busy;

  kra_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req_type   (in_req.req_type),
    .read_index (in_req.read_index),
    .hit        (hit),
    .busy       (busy),
    .ctl        (ctl),
    .addr       (addr),
    .count      (count)
  );

  kra_ram #(
    .WIDTH ($bits(kra_entry_t)),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .rd_en (ctl.rd_en),
    .wr_en (ctl.wr_en),
    .addr  (addr),
    .wdata (wr_entry),
    .rdata (rd_entry)
  );

  // while idle the live request is used, else the captured one
  assign cur_dom   = busy ? dom_r : in_req.domain_id;
  assign cur_slice = busy ? slice_r : in_req.slice_time;

  // entry compare and runtime update on the ram read data
  assign hit = (rd_entry.domain == dom_r);
  assign sum = rd_entry.runtime + {32'b0, slice_r};

  always_comb begin
    wr_entry.domain = cur_dom;
    if (ctl.status == STAT_HIT) begin
      wr_entry.runtime = sum;
    end else begin
      wr_entry.runtime = {32'b0, cur_slice};
    end
  end

  always_comb begin
    dom_nxt   = dom_r;
    slice_nxt = slice_r;
    total_nxt = total_r;
    if (accept) begin
      dom_nxt   = in_req.domain_id;
      slice_nxt = in_req.slice_time;
      if (in_req.req_type == REQ_ADD) begin
        // dropped slices still count toward the total
        total_nxt = total_r + {32'b0, in_req.slice_time};
      end
    end
  end

  assign cnt_ext = 9'(count);

  // result beat
  always_comb begin
    out_res_nxt = out_res_r;
    if (ctl.emit) begin
      out_res_nxt.status      = ctl.status;
      out_res_nxt.entry_count = cnt_ext[5:0];
      out_res_nxt.out_total   = total_nxt;
      case (ctl.status)
        STAT_HIT: begin
          out_res_nxt.out_domain_id = cur_dom;
          out_res_nxt.out_runtime   = sum;
        end
        STAT_NEW: begin
          out_res_nxt.out_domain_id = cur_dom;
          out_res_nxt.out_runtime   = {32'b0, cur_slice};
        end
        STAT_FULL: begin
          out_res_nxt.out_domain_id = cur_dom;
          out_res_nxt.out_runtime   = '0;
        end
        STAT_RD_OK: begin
          out_res_nxt.out_domain_id = rd_entry.domain;
          out_res_nxt.out_runtime   = rd_entry.runtime;
        end
        default: begin
          out_res_nxt.out_domain_id = '0;
          out_res_nxt.out_runtime   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      out_valid_r <= ctl.emit;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    dom_r     <= dom_nxt;
    slice_r   <= slice_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

endmodule

### hdl/kra_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module kra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic             wr_en,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/kra_seq.sv
// sequencer: scan pointer, entry count and ram command generation
// depends on kra_pkg
`timescale 1ns / 1ps

module kra_seq #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  parameter int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               req_type,
  input  logic [4:0]         read_index,
  input  logic               hit,
  output logic               busy,
  output kra_pkg::kra_ctl_t  ctl,
  output logic [IDX_W-1:0]   addr,
  output logic [CNT_W-1:0]   count
);
  import kra_pkg::*;

  kra_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [8:0]       ridx_ext;
  logic             ridx_ok;
  logic             empty;
  logic             full;
  logic             last;

  assign ridx_ext = {4'b0, read_index};
  assign ridx_ok  = ridx_ext < 9'(used_r);
  assign empty    = (used_r == '0);
  assign full     = (used_r == CNT_W'(TABLE_ENTRIES));
  assign last     = ((CNT_W'(idx_r) + CNT_W'(1)) == used_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_READ) begin
            state_nxt = ridx_ok ? S_READ : S_IDLE;
          end else begin
            state_nxt = empty ? S_IDLE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit || last) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    ctl      = '0;
    ctl.status = STAT_HIT;
    addr     = idx_r;
    idx_nxt  = idx_r;
    used_nxt = used_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (req_type == REQ_READ) begin
            if (ridx_ok) begin
              ctl.rd_en = 1'b1;
              addr      = ridx_ext[IDX_W-1:0];
            end else begin
              ctl.emit   = 1'b1;
              ctl.status = STAT_RD_BAD;
            end
          end else if (empty) begin
            // first entry goes straight in
            ctl.wr_en  = 1'b1;
            ctl.emit   = 1'b1;
            ctl.status = STAT_NEW;
            addr       = '0;
            used_nxt   = used_r + CNT_W'(1);
          end else begin
            ctl.rd_en = 1'b1;
            addr      = '0;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          ctl.wr_en  = 1'b1;
          ctl.emit   = 1'b1;
          ctl.status = STAT_HIT;
          addr       = idx_r;
        end else if (!last) begin
          ctl.rd_en = 1'b1;
          idx_nxt   = idx_r + IDX_W'(1);
          addr      = idx_nxt;
        end else if (full) begin
          ctl.emit   = 1'b1;
          ctl.status = STAT_FULL;
        end else begin
          ctl.wr_en  = 1'b1;
          ctl.emit   = 1'b1;
          ctl.status = STAT_NEW;
          addr       = used_r[IDX_W-1:0];
          used_nxt   = used_r + CNT_W'(1);
        end
      end
      S_READ: begin
        ctl.emit   = 1'b1;
        ctl.status = STAT_RD_OK;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      used_r  <= used_nxt;
    end
  end

  assign busy  = (state_r != S_IDLE);
  assign count = used_nxt;

endmodule

### hdl/kra_checker.sv
// port-level checks for the keyed runtime accumulator, bound to the top level
// depends on kra_pkg and keyed_runtime_accumulator_unit_assert.svh
`timescale 1ns / 1ps
`include "keyed_runtime_accumulator_unit_assert.svh"

module kra_checker #(
  parameter int unsigned TABLE_ENTRIES = kra_pkg::TABLE_ENTRIES_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input kra_pkg::kra_res_t out_result
);
  import kra_pkg::*;

  localparam logic [6:0] ENTRIES_7 = 7'(TABLE_ENTRIES);

  logic big_table;
  logic bad_read_beat;
  logic full_beat;
  logic count_ok;
  logic bad_read_clean;
  logic drop_ok;

  assign big_table      = (TABLE_ENTRIES > 63);
  assign bad_read_beat  = out_valid && (out_result.status == STAT_RD_BAD);
  assign full_beat      = out_valid && (out_result.status == STAT_FULL);
  assign count_ok       = big_table || ({1'b0, out_result.entry_count} <= ENTRIES_7);
  assign bad_read_clean = (out_result.out_domain_id == '0) && (out_result.out_runtime == '0);
  assign drop_ok        = (out_result.out_runtime == '0) &&
                          (big_table || ({1'b0, out_result.entry_count} == ENTRIES_7));

  // a result beat always returns the block to idle
  `KRA_ASSERT_NOW(a_beat_idle, out_valid, !busy, "result beat while busy")

  // busy only rises after an accepted beat
  `KRA_ASSERT_NOW(a_busy_cause, busy && !$past(busy), $past(start), "busy without start")

  // count never exceeds the table size
  `KRA_ASSERT_NOW(a_count_max, out_valid, count_ok, "count above table size")

  // a read past the count carries no entry
  `KRA_ASSERT_NOW(a_bad_read, bad_read_beat, bad_read_clean, "bad read returned data")

  // a dropped slice only happens with a full table
  `KRA_ASSERT_NOW(a_full_drop, full_beat, drop_ok, "drop without full table")

endmodule

bind keyed_runtime_accumulator_unit kra_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_kra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_result (out_result)
);
